@@ rtl/core/msgl_pkg.sv @@
// ----------------------------------------------------------------------------
// Microphone sample gain and level statistics: shared definitions
// Widths, register indexes, limits and the payload structs that travel
// between the gain front end and the statistics stage.
// ----------------------------------------------------------------------------
package msgl_pkg;

   localparam int SampleW  = 16;
   localparam int MagW     = 16;
   localparam int SquareW  = 31;
   localparam int PeakW    = 15;
   localparam int CountW   = 32;
   localparam int EnergyW  = 63;
   localparam int GainW    = 4;
   localparam int ThreshW  = 16;
   localparam int CsrIndexW = 2;
   localparam int WideW    = 32;

   localparam logic [CsrIndexW-1:0] CSR_GAIN_SHIFT     = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_INVERT         = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_CLIP_THRESHOLD = 2'd2;

   localparam logic [ThreshW-1:0]       CLIP_THRESHOLD_RESET = 16'd32760;
   localparam logic signed [WideW-1:0]  SAMPLE_MAX_WIDE = 32'sd32767;
   localparam logic signed [WideW-1:0]  SAMPLE_MIN_WIDE = -32'sd32768;
   localparam logic signed [SampleW-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SampleW-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic [PeakW-1:0]         PEAK_MAX   = 15'h7FFF;
   localparam logic [CountW-1:0]        COUNT_MAX  = 32'hFFFF_FFFF;
   localparam logic [EnergyW-1:0]       ENERGY_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [GainW-1:0]   gain_shift;
      logic               invert_polarity;
      logic [ThreshW-1:0] clip_threshold;
   } cfg_type;

   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      logic [MagW-1:0]           mag;
      logic [SquareW-1:0]        square;
      logic                      start;
   } proc_type;

   // First member is the most significant: out_sample lands in the low bits.
   typedef struct packed {
      logic [CountW-1:0]         sample_count;
      logic [EnergyW-1:0]        square_sum;
      logic [CountW-1:0]         clipped_count;
      logic [PeakW-1:0]          peak_level;
      logic signed [SampleW-1:0] out_sample;
   } result_type;

endpackage

@@ rtl/core/msgl_front.sv @@
// ----------------------------------------------------------------------------
// Gain front end
// Registers the incoming sample, applies inversion and the saturating gain
// shift, forms the magnitude and its square, and registers the result.
// ----------------------------------------------------------------------------
module msgl_front (
   input  logic                                clock,
   input  logic                                reset,
   input  msgl_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [msgl_pkg::SampleW-1:0] in_sample,
   input  logic                                in_start,
   output logic                                out_valid,
   input  logic                                out_ready,
   output msgl_pkg::proc_type                  out_item
);

   logic                                a_valid_ff, a_valid_in;
   logic signed [msgl_pkg::SampleW-1:0] a_sample_ff, a_sample_in;
   logic                                a_start_ff, a_start_in;
   logic                                b_valid_ff, b_valid_in;
   msgl_pkg::proc_type                  b_item_ff, b_item_in;

   logic                                a_ready;
   logic                                b_ready;
   logic signed [msgl_pkg::SampleW-1:0] turned;
   logic signed [msgl_pkg::WideW-1:0]   wide;
   logic signed [msgl_pkg::SampleW-1:0] gained;
   logic [msgl_pkg::MagW-1:0]           mag;
   logic [2*msgl_pkg::MagW-1:0]         square_full;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Negation wraps in 16 bits, so the most negative sample maps to itself.
   always_comb begin
      turned = cfg.invert_polarity ? (16'sd0 - a_sample_ff) : a_sample_ff;
      wide   = {{(msgl_pkg::WideW - msgl_pkg::SampleW){turned[msgl_pkg::SampleW-1]}}, turned}
               <<< cfg.gain_shift;
      if (wide > msgl_pkg::SAMPLE_MAX_WIDE) begin
         gained = msgl_pkg::SAMPLE_MAX;
      end else if (wide < msgl_pkg::SAMPLE_MIN_WIDE) begin
         gained = msgl_pkg::SAMPLE_MIN;
      end else begin
         gained = wide[msgl_pkg::SampleW-1:0];
      end
      mag = gained[msgl_pkg::SampleW-1] ? (16'd0 - gained) : gained;
      square_full = mag * mag;
   end

   always_comb begin
      a_valid_in  = a_ready ? in_valid : a_valid_ff;
      a_sample_in = (a_ready && in_valid) ? in_sample : a_sample_ff;
      a_start_in  = (a_ready && in_valid) ? in_start : a_start_ff;
      b_valid_in  = b_ready ? a_valid_ff : b_valid_ff;
      b_item_in   = b_item_ff;
      if (b_ready && a_valid_ff) begin
         b_item_in.sample = gained;
         b_item_in.mag    = mag;
         b_item_in.square = square_full[msgl_pkg::SquareW-1:0];
         b_item_in.start  = a_start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sample_ff <= a_sample_in;
      a_start_ff  <= a_start_in;
      b_item_ff   <= b_item_in;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

@@ rtl/core/msgl_stats.sv @@
// ----------------------------------------------------------------------------
// Level statistics
// Keeps peak, clip count, energy and sample count, all saturating, and
// registers each processed sample together with the updated statistics.
// ----------------------------------------------------------------------------
module msgl_stats (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [msgl_pkg::ThreshW-1:0]        clip_threshold,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  msgl_pkg::proc_type                  in_item,
   output logic                                out_valid,
   input  logic                                out_ready,
   output msgl_pkg::result_type                out_result
);

   logic [msgl_pkg::PeakW-1:0]   peak_ff, peak_in;
   logic [msgl_pkg::CountW-1:0]  clip_ff, clip_in;
   logic [msgl_pkg::EnergyW-1:0] energy_ff, energy_in;
   logic [msgl_pkg::CountW-1:0]  count_ff, count_in;
   logic                         valid_ff, valid_in;
   msgl_pkg::result_type         result_ff, result_in;

   logic                         take;
   logic [msgl_pkg::PeakW-1:0]   peak_base;
   logic [msgl_pkg::CountW-1:0]  clip_base;
   logic [msgl_pkg::EnergyW-1:0] energy_base;
   logic [msgl_pkg::CountW-1:0]  count_base;
   logic [msgl_pkg::EnergyW:0]   energy_sum;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      // A start flag clears the statistics before this sample is counted.
      peak_base   = in_item.start ? '0 : peak_ff;
      clip_base   = in_item.start ? '0 : clip_ff;
      energy_base = in_item.start ? '0 : energy_ff;
      count_base  = in_item.start ? '0 : count_ff;

      peak_in   = peak_ff;
      clip_in   = clip_ff;
      energy_in = energy_ff;
      count_in  = count_ff;
      valid_in  = in_ready ? in_valid : valid_ff;
      result_in = result_ff;

      energy_sum = {1'b0, energy_base}
                   + {{(msgl_pkg::EnergyW + 1 - msgl_pkg::SquareW){1'b0}}, in_item.square};

      if (take) begin
         peak_in = peak_base;
         if (in_item.mag > {1'b0, peak_base}) begin
            // A magnitude of 32768 still records a peak of 32767.
            peak_in = in_item.mag[msgl_pkg::MagW-1] ? msgl_pkg::PEAK_MAX
                                                   : in_item.mag[msgl_pkg::PeakW-1:0];
         end
         energy_in = energy_sum[msgl_pkg::EnergyW] ? msgl_pkg::ENERGY_MAX
                                                   : energy_sum[msgl_pkg::EnergyW-1:0];
         count_in  = (count_base == msgl_pkg::COUNT_MAX) ? count_base : count_base + 1'b1;
         clip_in   = clip_base;
         if (in_item.mag >= clip_threshold && clip_base != msgl_pkg::COUNT_MAX) begin
            clip_in = clip_base + 1'b1;
         end
         result_in.out_sample    = in_item.sample;
         result_in.peak_level    = peak_in;
         result_in.clipped_count = clip_in;
         result_in.square_sum    = energy_in;
         result_in.sample_count  = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff   <= '0;
         clip_ff   <= '0;
         energy_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         peak_ff   <= peak_in;
         clip_ff   <= clip_in;
         energy_ff <= energy_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

@@ rtl/core/mic_sample_gain_and_level_stats.sv @@
// ----------------------------------------------------------------------------
// Microphone sample gain and level statistics
// Saturating gain for 16-bit PCM samples with a running peak, clip count,
// energy and sample count.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side does not stall and
// returns one result per item through these registers: an input register,
// a register after the gain shift and 16x16 squarer, and the result register
// that also holds the running statistics, whose update (one 63-bit saturating
// add) closes the loop from one item to the next. Stalls on
// the result side hold every stage in place and reach the input in the same
// cycle. Configuration writes are taken at any time on the csr_ channel but
// must only be made while no item is in flight. Setting the start flag in tuser
// clears the statistics before that item is counted.
module mic_sample_gain_and_level_stats (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [15:0] in_sample
   input  logic [0:0]   req_tuser,   // [0] start_of_recording
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] out_sample, [30:16] peak_level, [62:31] clipped_count,
   // [125:63] square_sum, [157:126] sample_count, [159:158] zero
   output logic [159:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   msgl_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 mid_valid;
   logic                 mid_ready;
   msgl_pkg::proc_type   mid_item;
   msgl_pkg::result_type result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            msgl_pkg::CSR_GAIN_SHIFT: begin
               cfg_in.gain_shift = csr_data[msgl_pkg::GainW-1:0];
            end
            msgl_pkg::CSR_INVERT: begin
               cfg_in.invert_polarity = csr_data[0];
            end
            msgl_pkg::CSR_CLIP_THRESHOLD: begin
               cfg_in.clip_threshold = csr_data[msgl_pkg::ThreshW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_shift      <= '0;
         cfg_ff.invert_polarity <= 1'b0;
         cfg_ff.clip_threshold  <= msgl_pkg::CLIP_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msgl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (req_tdata),
      .in_start  (req_tuser[0]),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   msgl_stats u_stats (
      .clock          (clock),
      .reset          (reset),
      .clip_threshold (cfg_ff.clip_threshold),
      .in_valid       (mid_valid),
      .in_ready       (mid_ready),
      .in_item        (mid_item),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_result     (result)
   );

   assign rsp_tdata = {2'b00, result};

endmodule

@@ rtl/core/msgl_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Checks the result stream of the top level against the relations that its
// statistics must keep.
// ----------------------------------------------------------------------------
module msgl_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata
);

   // A result that waits must hold still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Every result counts at least its own sample.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[157:126] != 32'd0)
      else $error("sample count is zero on a result item");

   // Clipped samples are a subset of all samples since the last clear.
   a_clip_le_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[62:31] <= rsp_tdata[157:126])
      else $error("clip count exceeds sample count");

   // The peak already includes the sample that comes with it.
   a_peak_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[15] |-> rsp_tdata[14:0] <= rsp_tdata[30:16])
      else $error("peak level below the current positive sample");

   a_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind mic_sample_gain_and_level_stats msgl_checker u_msgl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
